[rtl/core/bth_pkg.sv]
package bth_pkg;

  localparam int TAG_W = 21;
  localparam int LEN_W = 32;
  localparam int POS_W = 32;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_END       = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_TAG_LONG  = 3'd3,
    ST_BAD_COUNT = 3'd4
  } status_t;

  // parser phase
  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_TAG  = 2'd1,
    PH_LEN  = 2'd2,
    PH_LENX = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [2:0]         class_and_form;
    logic [TAG_W-1:0]   tag_number;
    logic [LEN_W-1:0]   content_length;
    logic               is_indefinite;
    logic [2:0]         noncanonical_at;
    logic [3:0]         header_bytes;
    logic [POS_W-1:0]   stream_position;
  } out_word_t;

endpackage

[rtl/core/bth_word_if.sv]
interface bth_word_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/ber_tlv_header_parser.sv]
// BER tag/length header parser. Feed one header byte (or an end-of-data mark)
// per word on in_word; a result word is registered onto out_word in the cycle
// after the byte that completes a header, hits an error, or after the end mark. One
// input word is taken every cycle: the only stall is a full result register
// whose word is not taken in that same cycle. Content bytes are not consumed
// here; the caller skips content_length bytes before the next header.
// stream_position counts every data byte taken since reset.
module ber_tlv_header_parser #(
  parameter int MAX_HEADER_INDEX = 5,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  bth_word_if.sink   in_word,
  bth_word_if.source out_word
);
  import bth_pkg::*;

  localparam int TCW = $clog2(MAX_HEADER_INDEX);
  localparam int LCW = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int SW  = 5;

  phase_t             phase_r, phase_nxt;
  logic [2:0]         class_r, class_nxt;
  logic [TAG_W-1:0]   tag_acc_r, tag_acc_nxt;
  logic [TCW-1:0]     tag_cnt_r, tag_cnt_nxt;
  logic [LCW-1:0]     len_exp_r, len_exp_nxt;
  logic [LCW-1:0]     len_seen_r, len_seen_nxt;
  logic [LEN_W-1:0]   len_acc_r, len_acc_nxt;
  logic [7:0]         first_r, first_nxt;
  logic               red_r, red_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               out_valid_r;
  out_word_t          out_data_r;

  logic               take;
  logic               emit;
  out_word_t          res;
  logic [7:0]         b;
  logic [TCW-1:0]     tag_cnt_inc;
  logic [LCW-1:0]     len_seen_inc;
  logic [LEN_W-1:0]   len_acc_sh;
  logic [SW-1:0]      len_start;
  logic [SW-1:0]      hb_sum;

  assign in_word.ready = !out_valid_r || out_word.ready;
  assign take          = in_word.valid && in_word.ready;
  assign b             = in_word.data.data_byte;

  assign tag_cnt_inc  = tag_cnt_r + TCW'(1);
  assign len_seen_inc = len_seen_r + LCW'(1);
  assign len_acc_sh   = {len_acc_r[LEN_W-9:0], b};
  assign len_start    = SW'(tag_cnt_r) + SW'(2);

  // next state and result word
  always_comb begin
    phase_nxt    = phase_r;
    class_nxt    = class_r;
    tag_acc_nxt  = tag_acc_r;
    tag_cnt_nxt  = tag_cnt_r;
    len_exp_nxt  = len_exp_r;
    len_seen_nxt = len_seen_r;
    len_acc_nxt  = len_acc_r;
    first_nxt    = first_r;
    red_nxt      = red_r;
    pos_nxt      = pos_r;
    emit         = 1'b0;
    hb_sum       = '0;
    res          = '0;
    res.status   = ST_OK;
    res.class_and_form  = class_r;
    res.stream_position = pos_r;

    if (in_word.data.end_of_data) begin
      emit = 1'b1;
      if (phase_r == PH_ID) begin
        res.status         = ST_END;
        res.class_and_form = '0;
      end else begin
        res.status = ST_TRUNC;
        hb_sum     = SW'(tag_cnt_r) + SW'(1);
        if (phase_r == PH_LENX) hb_sum = hb_sum + SW'(len_seen_r) + SW'(1);
        res.header_bytes = hb_sum[3:0];
      end
    end else begin
      pos_nxt             = pos_r + POS_W'(1);
      res.stream_position = pos_nxt;
      unique case (phase_r)
        PH_ID: begin
          class_nxt = b[7:5];
          if (b[4:0] == 5'h1F) begin
            tag_acc_nxt = '0;
            phase_nxt   = PH_TAG;
          end else begin
            tag_acc_nxt = TAG_W'(b[4:0]);
            phase_nxt   = PH_LEN;
          end
        end
        PH_TAG: begin
          tag_acc_nxt = {tag_acc_r[TAG_W-8:0], b[6:0]};
          tag_cnt_nxt = tag_cnt_inc;
          if (tag_cnt_inc >= TCW'(MAX_HEADER_INDEX - 1)) begin
            emit             = 1'b1;
            res.status       = ST_TAG_LONG;
            hb_sum           = SW'(tag_cnt_inc) + SW'(1);
            res.header_bytes = hb_sum[3:0];
          end else if (!b[7]) begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          res.header_bytes = len_start[3:0];
          if (!b[7]) begin
            // short form
            emit               = 1'b1;
            res.tag_number     = tag_acc_r;
            res.content_length = LEN_W'(b);
          end else if (b[6:0] > 7'(MAX_LENGTH_BYTES)) begin
            emit       = 1'b1;
            res.status = ST_BAD_COUNT;
          end else if (b[6:0] == 7'd0) begin
            // indefinite
            emit              = 1'b1;
            res.tag_number    = tag_acc_r;
            res.is_indefinite = 1'b1;
          end else begin
            len_exp_nxt  = LCW'(b[6:0]);
            len_seen_nxt = '0;
            len_acc_nxt  = '0;
            phase_nxt    = PH_LENX;
          end
        end
        PH_LENX: begin
          if (len_seen_r == '0) begin
            first_nxt = b;
          end else if (len_seen_r == LCW'(1)) begin
            red_nxt = (first_r == 8'h00 && !b[7]) || (first_r == 8'hFF && b[7]);
          end
          len_acc_nxt  = len_acc_sh;
          len_seen_nxt = len_seen_inc;
          if (len_seen_inc >= len_exp_r) begin
            emit               = 1'b1;
            res.tag_number     = tag_acc_r;
            res.content_length = len_acc_sh;
            hb_sum             = len_start + SW'(len_exp_r);
            res.header_bytes   = hb_sum[3:0];
            if (len_exp_r > LCW'(1) && red_nxt) begin
              res.noncanonical_at = 3'(len_start - SW'(1));
            end else if (len_acc_sh < LEN_W'(128)) begin
              res.noncanonical_at = len_start[2:0];
            end
          end
        end
        default: ;
      endcase
    end

    // any result closes the current header
    if (emit) begin
      phase_nxt    = PH_ID;
      class_nxt    = '0;
      tag_acc_nxt  = '0;
      tag_cnt_nxt  = '0;
      len_exp_nxt  = '0;
      len_seen_nxt = '0;
      len_acc_nxt  = '0;
      first_nxt    = '0;
      red_nxt      = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ID;
      class_r    <= '0;
      tag_acc_r  <= '0;
      tag_cnt_r  <= '0;
      len_exp_r  <= '0;
      len_seen_r <= '0;
      len_acc_r  <= '0;
      first_r    <= '0;
      red_r      <= 1'b0;
      pos_r      <= '0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      class_r    <= class_nxt;
      tag_acc_r  <= tag_acc_nxt;
      tag_cnt_r  <= tag_cnt_nxt;
      len_exp_r  <= len_exp_nxt;
      len_seen_r <= len_seen_nxt;
      len_acc_r  <= len_acc_nxt;
      first_r    <= first_nxt;
      red_r      <= red_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) out_data_r <= res;
  end

  assign out_word.valid = out_valid_r;
  assign out_word.data  = out_data_r;

endmodule

[rtl/core/bth_checker.sv]
module bth_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_end,
  input logic                 out_valid,
  input logic                 out_ready,
  input bth_pkg::out_word_t   out_data
);
  import bth_pkg::*;

  // an end mark always produces a word next cycle
  a_end_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end |=> out_valid)
    else $error("end mark without result word");

  // input only stalls behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result register");

  // error and end words carry no tag or length
  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.tag_number == '0 && out_data.content_length == '0 &&
      !out_data.is_indefinite && out_data.noncanonical_at == '0)
    else $error("error word carries header fields");

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

endmodule

bind ber_tlv_header_parser bth_checker u_bth_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_word.valid),
  .in_ready  (in_word.ready),
  .in_end    (in_word.data.end_of_data),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .out_data  (out_word.data)
);
